FILE: rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, constants and helper functions for the complex ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	localparam int OpW    = 2;
	localparam int InW    = 16;
	localparam int OutW   = 32;
	localparam int ValW   = 33;
	localparam int DenW   = 32;
	localparam int FracW  = 16;
	localparam int NumW   = 48;
	localparam int DivSteps = 32;

	localparam logic [OutW-1:0] QMax = 32'h7FFF_FFFF;
	localparam logic [OutW-1:0] QMin = 32'h8000_0000;

	typedef enum logic [OpW-1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic                   is_div;
		logic                   dz;
		logic                   neg_re;
		logic                   neg_im;
		logic                   ovf_re;
		logic                   ovf_im;
		logic signed [ValW-1:0] val_re;
		logic signed [ValW-1:0] val_im;
	} side_t;

	typedef struct packed {
		logic [DenW-1:0]     rem;
		logic [OutW-1:0]     nb;
		logic [OutW-1:0]     q;
	} lane_t;

	typedef struct packed {
		logic [OutW-1:0] part;
		logic            sat;
	} part_t;

	// One restoring division step: bring in the next numerator bit and
	// subtract the divisor when it fits.
	function automatic lane_t div_step(input lane_t l, input logic [DenW-1:0] den);
		lane_t        r;
		logic [DenW:0] t;
		logic [DenW:0] d;
		logic          ge;
		t  = {l.rem, l.nb[OutW-1]};
		d  = t - {1'b0, den};
		ge = (t >= {1'b0, den});
		r.rem = ge ? d[DenW-1:0] : t[DenW-1:0];
		r.nb  = {l.nb[OutW-2:0], 1'b0};
		r.q   = {l.q[OutW-2:0], ge};
		return r;
	endfunction

	function automatic part_t sat_val(input logic signed [ValW-1:0] v);
		part_t r;
		if (v[ValW-1] != v[ValW-2]) begin
			r.part = v[ValW-1] ? QMin : QMax;
			r.sat  = 1'b1;
		end else begin
			r.part = v[OutW-1:0];
			r.sat  = 1'b0;
		end
		return r;
	endfunction

	function automatic part_t div_part(input logic [OutW-1:0] mag, input logic neg,
			input logic ovf);
		part_t r;
		if (ovf) begin
			r.part = neg ? QMin : QMax;
			r.sat  = 1'b1;
		end else if (neg) begin
			if (mag[OutW-1] && (|mag[OutW-2:0])) begin
				r.part = QMin;
				r.sat  = 1'b1;
			end else begin
				r.part = {OutW{1'b0}} - mag;
				r.sat  = 1'b0;
			end
		end else if (mag[OutW-1]) begin
			r.part = QMax;
			r.sat  = 1'b1;
		end else begin
			r.part = mag;
			r.sat  = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cau_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries the opcode and the two complex operands with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_req_if;
	logic                              valid;
	logic                              ready;
	logic [cau_pkg::OpW-1:0]           opcode;
	logic signed [cau_pkg::InW-1:0]    a_re;
	logic signed [cau_pkg::InW-1:0]    a_im;
	logic signed [cau_pkg::InW-1:0]    b_re;
	logic signed [cau_pkg::InW-1:0]    b_im;

	modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cau_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the complex result and its status with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cau_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [cau_pkg::OutW-1:0]   result_re;
	logic signed [cau_pkg::OutW-1:0]   result_im;
	logic [1:0]                        status;

	modport source (output valid, result_re, result_im, status, input ready);
	modport sink (input valid, result_re, result_im, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/cau_front.sv
// ----------------------------------------------------------------------------
// Complex arithmetic front end
// Three stages: products, sums, and divider setup with magnitude and range check.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              valid_in,
	input  wire logic [cau_pkg::OpW-1:0]           opcode,
	input  wire logic signed [cau_pkg::InW-1:0]    a_re,
	input  wire logic signed [cau_pkg::InW-1:0]    a_im,
	input  wire logic signed [cau_pkg::InW-1:0]    b_re,
	input  wire logic signed [cau_pkg::InW-1:0]    b_im,
	output logic                                   valid_out,
	output logic [cau_pkg::DenW-1:0]               den,
	output logic [cau_pkg::NumW-1:0]               num_re,
	output logic [cau_pkg::NumW-1:0]               num_im,
	output cau_pkg::side_t                         side
);

	logic                     vld_s1, vld_s2, vld_s3;
	cau_pkg::op_t             op_s1, op_s2;
	logic signed [31:0]       p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_r_s1, sq_i_s1;
	logic signed [16:0]       as_re_s1, as_im_s1;
	logic signed [cau_pkg::ValW-1:0] val_re_s2, val_im_s2;
	logic [cau_pkg::DenW-1:0] den_s2, den_s3;
	logic [cau_pkg::NumW-1:0] num_re_s3, num_im_s3;
	cau_pkg::side_t           side_s3;

	logic signed [cau_pkg::ValW-1:0] val_re_c, val_im_c;
	logic [cau_pkg::ValW-1:0]        mag_re_c, mag_im_c;
	logic [cau_pkg::NumW-1:0]        n_re_c, n_im_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= cau_pkg::op_t'(opcode);
			p_rr_s1  <= 32'(a_re) * 32'(b_re);
			p_ii_s1  <= 32'(a_im) * 32'(b_im);
			p_ri_s1  <= 32'(a_re) * 32'(b_im);
			p_ir_s1  <= 32'(a_im) * 32'(b_re);
			sq_r_s1  <= 32'(b_re) * 32'(b_re);
			sq_i_s1  <= 32'(b_im) * 32'(b_im);
			if (cau_pkg::op_t'(opcode) == cau_pkg::OP_SUB) begin
				as_re_s1 <= 17'(a_re) - 17'(b_re);
				as_im_s1 <= 17'(a_im) - 17'(b_im);
			end else begin
				as_re_s1 <= 17'(a_re) + 17'(b_re);
				as_im_s1 <= 17'(a_im) + 17'(b_im);
			end
		end
	end

	always_comb begin
		case (op_s1)
			cau_pkg::OP_MUL: begin
				val_re_c = 33'(p_rr_s1) - 33'(p_ii_s1);
				val_im_c = 33'(p_ri_s1) + 33'(p_ir_s1);
			end
			cau_pkg::OP_DIV: begin
				val_re_c = 33'(p_rr_s1) + 33'(p_ii_s1);
				val_im_c = 33'(p_ir_s1) - 33'(p_ri_s1);
			end
			default: begin
				val_re_c = {{8{as_re_s1[16]}}, as_re_s1, 8'b0};
				val_im_c = {{8{as_im_s1[16]}}, as_im_s1, 8'b0};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2     <= op_s1;
			val_re_s2 <= val_re_c;
			val_im_s2 <= val_im_c;
			den_s2    <= $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
		end
	end

	always_comb begin
		mag_re_c = val_re_s2[cau_pkg::ValW-1] ? (33'd0 - $unsigned(val_re_s2))
			: $unsigned(val_re_s2);
		mag_im_c = val_im_s2[cau_pkg::ValW-1] ? (33'd0 - $unsigned(val_im_s2))
			: $unsigned(val_im_s2);
		n_re_c = {mag_re_c[cau_pkg::OutW-1:0], {cau_pkg::FracW{1'b0}}};
		n_im_c = {mag_im_c[cau_pkg::OutW-1:0], {cau_pkg::FracW{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s3          <= den_s2;
			num_re_s3       <= n_re_c;
			num_im_s3       <= n_im_c;
			side_s3.is_div  <= (op_s2 == cau_pkg::OP_DIV);
			side_s3.dz      <= (den_s2 == '0);
			side_s3.neg_re  <= val_re_s2[cau_pkg::ValW-1];
			side_s3.neg_im  <= val_im_s2[cau_pkg::ValW-1];
			side_s3.ovf_re  <= ({16'b0, n_re_c[47:32]} >= den_s2);
			side_s3.ovf_im  <= ({16'b0, n_im_c[47:32]} >= den_s2);
			side_s3.val_re  <= val_re_s2;
			side_s3.val_im  <= val_im_s2;
		end
	end

	assign valid_out = vld_s3;
	assign den       = den_s3;
	assign num_re    = num_re_s3;
	assign num_im    = num_im_s3;
	assign side      = side_s3;

endmodule

`default_nettype wire

FILE: rtl/core/cau_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Two unsigned restoring dividers sharing one divisor, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        valid_in,
	input  wire logic [cau_pkg::DenW-1:0]    den,
	input  wire logic [cau_pkg::NumW-1:0]    num_re,
	input  wire logic [cau_pkg::NumW-1:0]    num_im,
	input  wire cau_pkg::side_t              side_in,
	output logic                             valid_out,
	output logic [cau_pkg::OutW-1:0]         q_re,
	output logic [cau_pkg::OutW-1:0]         q_im,
	output cau_pkg::side_t                   side_out
);

	localparam int N = cau_pkg::DivSteps;

	cau_pkg::lane_t           lane_re_s [1:N];
	cau_pkg::lane_t           lane_im_s [1:N];
	logic [cau_pkg::DenW-1:0] den_s     [1:N];
	cau_pkg::side_t           side_s    [1:N];
	logic                     vld_s     [1:N];

	cau_pkg::lane_t           init_re, init_im;

	always_comb begin
		init_re.rem = {16'b0, num_re[47:32]};
		init_re.nb  = num_re[31:0];
		init_re.q   = '0;
		init_im.rem = {16'b0, num_im[47:32]};
		init_im.nb  = num_im[31:0];
		init_im.q   = '0;
	end

	for (genvar g = 1; g <= N; g++) begin : g_stage
		if (g == 1) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en) begin
					vld_s[g] <= valid_in;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					lane_re_s[g] <= cau_pkg::div_step(init_re, den);
					lane_im_s[g] <= cau_pkg::div_step(init_im, den);
					den_s[g]     <= den;
					side_s[g]    <= side_in;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en) begin
					vld_s[g] <= vld_s[g-1];
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					lane_re_s[g] <= cau_pkg::div_step(lane_re_s[g-1], den_s[g-1]);
					lane_im_s[g] <= cau_pkg::div_step(lane_im_s[g-1], den_s[g-1]);
					den_s[g]     <= den_s[g-1];
					side_s[g]    <= side_s[g-1];
				end
			end
		end
	end

	assign valid_out = vld_s[N];
	assign q_re      = lane_re_s[N].q;
	assign q_im      = lane_im_s[N].q;
	assign side_out  = side_s[N];

endmodule

`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of Q8.8 complex operands to Q16.16 results.
//
//   Channel  Dir  Contents
//   req      in   opcode, a_re, a_im, b_re, b_im
//   rsp      out  result_re, result_im, status
//
// One word is accepted every cycle unless the output stalls; results pass the
// front end, the divider (one quotient bit a stage) and the output register.
// All operations share the same pipeline, so results leave in order.
// A stalled output register freezes the whole pipeline and holds req.ready low.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_top (
	input  wire logic clk,
	input  wire logic arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);

	logic                     en;
	logic                     f_valid, d_valid;
	logic [cau_pkg::DenW-1:0] f_den;
	logic [cau_pkg::NumW-1:0] f_num_re, f_num_im;
	cau_pkg::side_t           f_side, d_side;
	logic [cau_pkg::OutW-1:0] d_q_re, d_q_im;

	logic                     out_valid_q;
	logic [cau_pkg::OutW-1:0] res_re_q, res_im_q;
	cau_pkg::status_t         status_q;

	cau_pkg::part_t           pre_c, pim_c;
	logic [cau_pkg::OutW-1:0] re_c, im_c;
	cau_pkg::status_t         st_c;

	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (req.valid),
		.opcode    (req.opcode),
		.a_re      (req.a_re),
		.a_im      (req.a_im),
		.b_re      (req.b_re),
		.b_im      (req.b_im),
		.valid_out (f_valid),
		.den       (f_den),
		.num_re    (f_num_re),
		.num_im    (f_num_im),
		.side      (f_side)
	);

	cau_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (f_valid),
		.den       (f_den),
		.num_re    (f_num_re),
		.num_im    (f_num_im),
		.side_in   (f_side),
		.valid_out (d_valid),
		.q_re      (d_q_re),
		.q_im      (d_q_im),
		.side_out  (d_side)
	);

	always_comb begin
		if (d_side.is_div) begin
			pre_c = cau_pkg::div_part(d_q_re, d_side.neg_re, d_side.ovf_re);
			pim_c = cau_pkg::div_part(d_q_im, d_side.neg_im, d_side.ovf_im);
		end else begin
			pre_c = cau_pkg::sat_val(d_side.val_re);
			pim_c = cau_pkg::sat_val(d_side.val_im);
		end
		if (d_side.is_div && d_side.dz) begin
			re_c = '0;
			im_c = '0;
			st_c = cau_pkg::ST_DZ;
		end else begin
			re_c = pre_c.part;
			im_c = pim_c.part;
			st_c = (pre_c.sat || pim_c.sat) ? cau_pkg::ST_OVF : cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= re_c;
			res_im_q <= im_c;
			status_q <= st_c;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.result_re = res_re_q;
	assign rsp.result_im = res_im_q;
	assign rsp.status    = status_q;

endmodule

`default_nettype wire
